@@ sv/packet_header_tag_and_flow_hash_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the packet header tagger
// Shared shorthand for concurrent assertions on the clk/rst domain.
// ----------------------------------------------------------------------------
`ifndef PACKET_HEADER_TAG_AND_FLOW_HASH_MACROS_SVH
`define PACKET_HEADER_TAG_AND_FLOW_HASH_MACROS_SVH

// Checked on every rising edge of clk, suspended while rst is high.
`define PHTFH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge of clk, including during reset.
`define PHTFH_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/phtfh_pkg.sv @@
// ----------------------------------------------------------------------------
// Packet header tagger package
// Types, protocol constants and the hash mixing functions.
// ----------------------------------------------------------------------------
package phtfh_pkg;

  // Transport protocol numbers.
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  // Minimum transport bytes for each kind of tag.
  localparam logic [15:0] ICMP_MIN_BYTES  = 16'd2;
  localparam logic [15:0] PORTS_MIN_BYTES = 16'd4;
  localparam logic [15:0] TCP_HDR_BYTES   = 16'd20;

  // Seed multiplier applied to the source address.
  localparam logic [31:0] HASH_SEED_MUL = 32'd59;

  // Mix rounds, one per pipeline stage after the decode stage.
  localparam int          NUM_ROUNDS  = 5;
  localparam int          ROUND_W     = 3;
  localparam logic [2:0]  ROUND_DST   = 3'd1;
  localparam logic [2:0]  ROUND_SPORT = 3'd2;
  localparam logic [2:0]  ROUND_DPORT = 3'd3;
  localparam logic [2:0]  ROUND_TTL   = 3'd4;
  localparam logic [2:0]  ROUND_LEN   = 3'd5;

  // Decoded header fields that travel down the pipeline with the hash.
  typedef struct packed {
    logic        present;
    logic [7:0]  protocol;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  ttl;
    logic [7:0]  flags;
    logic [7:0]  ip_proto;
    logic [15:0] ip_len;
    logic [31:0] dst_ip;
  } info_t;

  // Per-stage control handed to each mix stage.
  typedef struct packed {
    logic advance;
    logic valid;
  } stage_ctl_t;

  // One shift-add-xor round, modulo 2^32.
  function automatic logic [31:0] mix_round(input logic [31:0] h, input logic [31:0] v);
    return h ^ ((h << 5) + (h >> 27) + v);
  endfunction

  // Value mixed in by a given round.
  function automatic logic [31:0] mix_value(input logic [ROUND_W-1:0] idx,
                                            input info_t info);
    logic [31:0] v;
    case (idx)
      ROUND_DST:   v = info.dst_ip;
      ROUND_SPORT: v = {info.sport, 16'h0000};
      ROUND_DPORT: v = {16'h0000, info.dport};
      ROUND_TTL:   v = {info.ttl, info.flags, 16'h0000};
      ROUND_LEN:   v = {16'h0000, ({info.ip_proto, 8'h00} | info.ip_len)};
      default:     v = 32'h0000_0000;
    endcase
    return v;
  endfunction

endpackage

@@ sv/phtfh_mix_stage.sv @@
// ----------------------------------------------------------------------------
// Flow hash mix stage
// One registered shift-add-xor round; the decoded fields ride along.
// ----------------------------------------------------------------------------
module phtfh_mix_stage
  import phtfh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  stage_ctl_t  ctl,
  input  logic [31:0] h_in,
  input  logic [31:0] v_in,
  input  info_t       info_in,
  output logic        valid,
  output logic [31:0] h,
  output info_t       info
);

  // Valid bit moves only when the pipeline advances.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.advance) begin
      valid <= ctl.valid;
    end
  end

  // Hash round and side fields; held while stalled.
  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      h    <= mix_round(h_in, v_in);
      info <= info_in;
    end
  end

endmodule

@@ sv/packet_header_tag_and_flow_hash.sv @@
// ----------------------------------------------------------------------------
// Packet header tagger with flow hash
// Tags each parsed IPv4 header with protocol, ports and a 32-bit flow hash.
// ----------------------------------------------------------------------------
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   input   | in_valid / in_ready  | header_present .. tcp_flag_byte
//   output  | out_valid / out_ready| tag_valid, protocol_tag, port tags, hash
//
// Six register stages: decode plus seed multiply, then one mix round per
// stage. A word enters every cycle when the output is not stalled and moves
// through the decode stage and each mix stage in turn. The last stage is the
// output register; while it holds an untaken word the whole pipeline
// freezes, and in_ready is low. Reset clears only the stage valid bits.
// ----------------------------------------------------------------------------
module packet_header_tag_and_flow_hash
  import phtfh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        header_present,
  input  logic [31:0] src_ip,
  input  logic [31:0] dst_ip,
  input  logic [7:0]  ip_proto,
  input  logic [7:0]  ttl,
  input  logic [15:0] ip_len,
  input  logic [7:0]  trans_proto,
  input  logic [15:0] trans_bytes,
  input  logic [15:0] first_word,
  input  logic [15:0] second_word,
  input  logic [7:0]  tcp_flag_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        tag_valid,
  output logic [7:0]  protocol_tag,
  output logic [15:0] src_port_tag,
  output logic [15:0] dst_port_tag,
  output logic [31:0] flow_hash
);

  logic        advance;
  info_t       dec_info;
  logic        valid_q [0:NUM_ROUNDS];
  logic [31:0] h_q     [0:NUM_ROUNDS];
  info_t       info_q  [0:NUM_ROUNDS];

  // The pipeline moves whenever the output register is free or being taken.
  assign advance  = !valid_q[NUM_ROUNDS] || out_ready;
  assign in_ready = advance;

  // Decode the protocol tag and the ports and flags that enter the hash.
  always_comb begin
    dec_info          = '0;
    dec_info.present  = header_present;
    dec_info.ttl      = ttl;
    dec_info.ip_proto = ip_proto;
    dec_info.ip_len   = ip_len;
    dec_info.dst_ip   = dst_ip;
    if (header_present) begin
      dec_info.protocol = trans_proto;
      if (trans_proto == PROTO_ICMP && trans_bytes >= ICMP_MIN_BYTES) begin
        dec_info.sport = {8'h00, first_word[15:8]};
        dec_info.dport = {8'h00, first_word[7:0]};
      end else if ((trans_proto == PROTO_TCP || trans_proto == PROTO_UDP) &&
                   trans_bytes >= PORTS_MIN_BYTES) begin
        dec_info.sport = first_word;
        dec_info.dport = second_word;
        if (trans_proto == PROTO_TCP && trans_bytes >= TCP_HDR_BYTES) begin
          dec_info.flags = tcp_flag_byte;
        end
      end
    end
  end

  // Stage zero valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q[0] <= 1'b0;
    end else if (advance) begin
      valid_q[0] <= in_valid;
    end
  end

  // Stage zero payload: seed hash and decoded fields.
  always_ff @(posedge clk) begin
    if (advance) begin
      h_q[0]    <= src_ip * HASH_SEED_MUL;
      info_q[0] <= dec_info;
    end
  end

  // One mix round per stage.
  for (genvar g = 1; g <= NUM_ROUNDS; g++) begin : g_round
    stage_ctl_t ctl;
    logic [31:0] v;

    assign ctl.advance = advance;
    assign ctl.valid   = valid_q[g-1];
    assign v           = mix_value(ROUND_W'(g), info_q[g-1]);

    phtfh_mix_stage u_stage (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .h_in    (h_q[g-1]),
      .v_in    (v),
      .info_in (info_q[g-1]),
      .valid   (valid_q[g]),
      .h       (h_q[g]),
      .info    (info_q[g])
    );
  end

  // Output word; the hash reads as zero when the header was missing.
  assign out_valid    = valid_q[NUM_ROUNDS];
  assign tag_valid    = info_q[NUM_ROUNDS].present;
  assign protocol_tag = info_q[NUM_ROUNDS].protocol;
  assign src_port_tag = info_q[NUM_ROUNDS].sport;
  assign dst_port_tag = info_q[NUM_ROUNDS].dport;
  assign flow_hash    = info_q[NUM_ROUNDS].present ? h_q[NUM_ROUNDS] : 32'h0000_0000;

endmodule

@@ sv/phtfh_checker.sv @@
// ----------------------------------------------------------------------------
// Packet header tagger checker
// Port-level assertions on the tagger, bound to the top level.
// ----------------------------------------------------------------------------
`include "packet_header_tag_and_flow_hash_macros.svh"

module phtfh_checker
  import phtfh_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        tag_valid,
  input logic [7:0]  protocol_tag,
  input logic [15:0] src_port_tag,
  input logic [15:0] dst_port_tag,
  input logic [31:0] flow_hash
);

  // A stalled output word stays put.
  `PHTFH_ASSERT(a_out_hold,
    out_valid && !out_ready |=> out_valid && $stable(flow_hash) &&
    $stable(src_port_tag) && $stable(dst_port_tag),
    "output word changed while stalled")

  // A missing header yields an all-zero word.
  `PHTFH_ASSERT(a_missing_zero,
    out_valid && !tag_valid |-> protocol_tag == 8'h00 && src_port_tag == 16'h0000 &&
    dst_port_tag == 16'h0000 && flow_hash == 32'h0000_0000,
    "missing header gave nonzero tags")

  // ICMP type and code are single bytes; unknown protocols carry no ports.
  `PHTFH_ASSERT(a_port_range,
    out_valid && tag_valid && protocol_tag != PROTO_TCP && protocol_tag != PROTO_UDP |->
    src_port_tag[15:8] == 8'h00 && dst_port_tag[15:8] == 8'h00,
    "port tag too wide for protocol")

  // Nothing comes out in the cycle after reset.
  `PHTFH_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "output valid right after reset")

endmodule

bind packet_header_tag_and_flow_hash phtfh_checker u_phtfh_checker (.*);

@@ tb/tb_packet_header_tag_and_flow_hash.sv @@
// ----------------------------------------------------------------------------
// Testbench for the packet header tagger with flow hash
// Drives parsed IPv4 header words through the valid/ready input and compares
// every tag word that leaves the block with a locally computed prediction of
// protocol, ports and flow hash. Directed words cover missing headers, short
// transport headers and the TCP flag rule; random words follow in bursts
// while the output side stalls on its own pattern and once holds off long
// enough to back the pipeline up.
// ----------------------------------------------------------------------------
module tb_packet_header_tag_and_flow_hash
  import phtfh_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // One parsed header word as offered on the input channel.
  typedef struct packed {
    logic        present;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [7:0]  ip_proto;
    logic [7:0]  ttl;
    logic [15:0] ip_len;
    logic [7:0]  trans_proto;
    logic [15:0] trans_bytes;
    logic [15:0] first_word;
    logic [15:0] second_word;
    logic [7:0]  flags;
  } hdr_t;

  // One tag word as delivered on the output channel.
  typedef struct packed {
    logic        tag_valid;
    logic [7:0]  protocol;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] hash;
  } tag_t;

  // Keeps the tags still owed by the block, oldest first, and checks arrivals.
  class tag_book;
    tag_t pending_tags[$];
    int   failures;

    function new();
      failures = 0;
    endfunction

    // One shift-add-xor step of the flow hash, modulo 2^32.
    static function logic [31:0] stir(logic [31:0] acc, logic [31:0] v);
      logic [31:0] sum;
      sum = (acc << 5) + (acc >> 27) + v;
      return acc ^ sum;
    endfunction

    // Tag that a header word must produce.
    static function tag_t expected_tag(hdr_t h);
      tag_t        t;
      logic [7:0]  fl;
      logic [31:0] acc;
      t  = '0;
      fl = '0;
      if (!h.present) return t;
      t.tag_valid = 1'b1;
      t.protocol  = h.trans_proto;
      if (h.trans_proto == PROTO_ICMP && h.trans_bytes >= ICMP_MIN_BYTES) begin
        // ICMP type and code take the port slots.
        t.sport = {8'h00, h.first_word[15:8]};
        t.dport = {8'h00, h.first_word[7:0]};
      end else if ((h.trans_proto == PROTO_TCP || h.trans_proto == PROTO_UDP) &&
                   h.trans_bytes >= PORTS_MIN_BYTES) begin
        t.sport = h.first_word;
        t.dport = h.second_word;
        if (h.trans_proto == PROTO_TCP && h.trans_bytes >= TCP_HDR_BYTES) fl = h.flags;
      end
      acc    = h.src_ip * HASH_SEED_MUL;
      acc    = stir(acc, h.dst_ip);
      acc    = stir(acc, {t.sport, 16'h0000});
      acc    = stir(acc, {16'h0000, t.dport});
      acc    = stir(acc, {h.ttl, fl, 16'h0000});
      acc    = stir(acc, {16'h0000, ({h.ip_proto, 8'h00} | h.ip_len)});
      t.hash = acc;
      return t;
    endfunction

    // Called for each header word the block accepts.
    function void note_header(hdr_t h);
      pending_tags.push_back(expected_tag(h));
    endfunction

    function void compare(string name, logic [31:0] exp_v, logic [31:0] got_v);
      if (exp_v !== got_v) begin
        failures++;
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, got_v);
      end
    endfunction

    // Called for each tag word the block delivers.
    function void check_tag(tag_t got);
      tag_t exp_t;
      if (pending_tags.size() == 0) begin
        failures++;
        $display("%0t: unexpected tag word: expected none, actual %h", $time, got);
        return;
      end
      exp_t = pending_tags.pop_front();
      compare("tag_valid", 32'(exp_t.tag_valid), 32'(got.tag_valid));
      compare("protocol_tag", 32'(exp_t.protocol), 32'(got.protocol));
      compare("src_port_tag", 32'(exp_t.sport), 32'(got.sport));
      compare("dst_port_tag", 32'(exp_t.dport), 32'(got.dport));
      compare("flow_hash", exp_t.hash, got.hash);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        header_present = 1'b0;
  logic [31:0] src_ip = '0;
  logic [31:0] dst_ip = '0;
  logic [7:0]  ip_proto = '0;
  logic [7:0]  ttl = '0;
  logic [15:0] ip_len = '0;
  logic [7:0]  trans_proto = '0;
  logic [15:0] trans_bytes = '0;
  logic [15:0] first_word = '0;
  logic [15:0] second_word = '0;
  logic [7:0]  tcp_flag_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        tag_valid;
  logic [7:0]  protocol_tag;
  logic [15:0] src_port_tag;
  logic [15:0] dst_port_tag;
  logic [31:0] flow_hash;

  // Set once the random words start; it arms the long output hold-off.
  logic        random_phase = 1'b0;
  logic        hold_rx = 1'b0;

  tag_book     book = new();
  hdr_t        header_queue[$];

  packet_header_tag_and_flow_hash DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .header_present(header_present),
    .src_ip        (src_ip),
    .dst_ip        (dst_ip),
    .ip_proto      (ip_proto),
    .ttl           (ttl),
    .ip_len        (ip_len),
    .trans_proto   (trans_proto),
    .trans_bytes   (trans_bytes),
    .first_word    (first_word),
    .second_word   (second_word),
    .tcp_flag_byte (tcp_flag_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .tag_valid     (tag_valid),
    .protocol_tag  (protocol_tag),
    .src_port_tag  (src_port_tag),
    .dst_port_tag  (dst_port_tag),
    .flow_hash     (flow_hash)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Header with the given presence, protocol and length; other fields random.
  function automatic hdr_t header_with(logic present, logic [7:0] proto, logic [15:0] nbytes);
    hdr_t h;
    h.present     = present;
    h.src_ip      = $urandom;
    h.dst_ip      = $urandom;
    h.ip_proto    = proto;
    h.ttl         = 8'($urandom_range(0, 255));
    h.ip_len      = 16'($urandom_range(0, 65535));
    h.trans_proto = proto;
    h.trans_bytes = nbytes;
    h.first_word  = 16'($urandom_range(0, 65535));
    h.second_word = 16'($urandom_range(0, 65535));
    h.flags       = 8'($urandom_range(0, 255));
    return h;
  endfunction

  // Mostly well-formed ICMP, TCP and UDP headers, with some odd protocols,
  // short transport headers and missing headers mixed in.
  function automatic hdr_t random_header();
    hdr_t        h;
    int unsigned sel;
    logic [7:0]  proto;
    logic [15:0] nbytes;
    sel = $urandom_range(0, 9);
    if (sel < 3) proto = PROTO_ICMP;
    else if (sel < 6) proto = PROTO_TCP;
    else if (sel < 8) proto = PROTO_UDP;
    else proto = 8'($urandom_range(0, 255));
    nbytes = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 24));
    h = header_with($urandom_range(0, 9) != 0, proto, nbytes);
    if ($urandom_range(0, 3) == 0) h.ip_proto = 8'($urandom_range(0, 255));
    return h;
  endfunction

  // Directed words: missing headers, length thresholds, the flag rule and
  // field extremes.
  task automatic add_directed();
    hdr_t h;
    h = '1;
    h.present = 1'b0;
    header_queue.push_back(h);
    h = '0;
    header_queue.push_back(h);
    header_queue.push_back(header_with(1'b1, PROTO_ICMP, 16'd0));
    header_queue.push_back(header_with(1'b1, PROTO_ICMP, 16'd1));
    header_queue.push_back(header_with(1'b1, PROTO_ICMP, 16'd2));
    h = header_with(1'b1, PROTO_ICMP, 16'hFFFF);
    h.first_word = 16'hFFFF;
    header_queue.push_back(h);
    header_queue.push_back(header_with(1'b1, PROTO_TCP, 16'd3));
    header_queue.push_back(header_with(1'b1, PROTO_TCP, 16'd4));
    h = header_with(1'b1, PROTO_TCP, 16'd19);
    h.flags = 8'hFF;
    header_queue.push_back(h);
    h = header_with(1'b1, PROTO_TCP, 16'd20);
    h.flags = 8'hFF;
    header_queue.push_back(h);
    h = header_with(1'b1, PROTO_TCP, 16'hFFFF);
    h.flags = 8'h80;
    header_queue.push_back(h);
    header_queue.push_back(header_with(1'b1, PROTO_UDP, 16'd3));
    header_queue.push_back(header_with(1'b1, PROTO_UDP, 16'd4));
    h = header_with(1'b1, PROTO_UDP, 16'd20);
    h.flags = 8'hFF;
    header_queue.push_back(h);
    header_queue.push_back(header_with(1'b1, 8'd0, 16'd40));
    header_queue.push_back(header_with(1'b1, 8'd255, 16'd40));
    header_queue.push_back(header_with(1'b1, 8'd2, 16'd40));
    // All fields at their maximum with a full TCP header.
    h = '1;
    h.trans_proto = PROTO_TCP;
    header_queue.push_back(h);
    // Present but all other fields zero, with a UDP header.
    h = '0;
    h.present     = 1'b1;
    h.trans_proto = PROTO_UDP;
    h.trans_bytes = 16'd8;
    header_queue.push_back(h);
    // IP protocol byte that disagrees with the transport protocol.
    h = header_with(1'b1, PROTO_ICMP, 16'd8);
    h.ip_proto = PROTO_TCP;
    header_queue.push_back(h);
  endtask

  // Offers one word and returns at the edge where it is accepted.
  task automatic send_header(hdr_t h);
    in_valid       <= 1'b1;
    header_present <= h.present;
    src_ip         <= h.src_ip;
    dst_ip         <= h.dst_ip;
    ip_proto       <= h.ip_proto;
    ttl            <= h.ttl;
    ip_len         <= h.ip_len;
    trans_proto    <= h.trans_proto;
    trans_bytes    <= h.trans_bytes;
    first_word     <= h.first_word;
    second_word    <= h.second_word;
    tcp_flag_byte  <= h.flags;
    do @(posedge clk); while (!in_ready);
    book.note_header(h);
  endtask

  // Output side: checks delivered words and stalls on a rotating pattern.
  initial begin : rx_side
    int unsigned cyc;
    logic        ready_bit;
    tag_t        got;
    cyc = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        got.tag_valid = tag_valid;
        got.protocol  = protocol_tag;
        got.sport     = src_port_tag;
        got.dport     = dst_port_tag;
        got.hash      = flow_hash;
        book.check_tag(got);
      end
      cyc++;
      case ((cyc / 97) % 4)
        0:       ready_bit = 1'b1;
        1:       ready_bit = ($urandom_range(0, 3) != 0);
        2:       ready_bit = cyc[0];
        default: ready_bit = ($urandom_range(0, 1) != 0);
      endcase
      out_ready <= ready_bit && !hold_rx;
    end
  end

  // One long output hold-off while the input keeps offering words.
  initial begin : long_hold
    wait (random_phase);
    repeat (20) @(posedge clk);
    hold_rx <= 1'b1;
    repeat (150) @(posedge clk);
    hold_rx <= 1'b0;
  end

  // Stimulus and end of run.
  initial begin : tx_side
    int unsigned n_directed;
    int unsigned sent;
    int unsigned burst;
    add_directed();
    n_directed = header_queue.size();
    repeat (750) header_queue.push_back(random_header());

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Bursts of random length, separated by random gaps or none at all.
    sent = 0;
    while (sent < header_queue.size()) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && sent < header_queue.size()) begin
        if (sent == n_directed) random_phase = 1'b1;
        send_header(header_queue[sent]);
        sent++;
        burst--;
      end
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    // Drain, then allow a few pipeline lengths for stray words.
    while (book.pending_tags.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (book.failures == 0 && book.pending_tags.size() == 0) begin
      $display("PASS packet_header_tag_and_flow_hash");
    end else begin
      $display("FAIL packet_header_tag_and_flow_hash");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin : watchdog
    #2_000_000;
    $display("FAIL packet_header_tag_and_flow_hash");
    $finish;
  end

endmodule
